FILE: hw/rtl/tsbq_pkg.sv
// Package for the two-stack bounded queue: payload words, codes and the control state type.
// Used by tsbq_stack_mem and two_stack_bounded_queue_core; depends on nothing.
package tsbq_pkg;

  localparam int DATA_W        = 32;
  localparam int CFG_W         = 7;
  localparam int STATUS_W      = 2;
  localparam int TSBQ_DEPTH    = 64;
  localparam int CFG_IDX_W     = 1;
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_DEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CAP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CAP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] add_value;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] out_value;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XFER,
    ST_FINISH,
    ST_POP
  } state_t;

endpackage

FILE: hw/rtl/two_stack_bounded_queue_core.sv
// Two-stack bounded FIFO queue: control state machine, counters and two stack memories.
// An add that fits gives no word and leaves the core idle; an error word appears the
// cycle after acceptance; a delete from a non-empty output stack gives its word in ST_POP.
// A transfer moves the entries with one memory read per cycle through the input store.
// The core is busy through a transfer and a pop and takes no new word then; no result stalls.
// Reset clears counters and state and sets both capacities to 64; the stack memories are not cleared.
module two_stack_bounded_queue_core
  import tsbq_pkg::*;
#(
  parameter int DEPTH = TSBQ_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             in_word,
  output logic                 out_strobe,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CAPW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [CAPW-1:0] DEPTH_C = CAPW'(DEPTH);
  localparam logic [CAPW-1:0] ONE_C   = CAPW'(1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]    cap_first_r, cap_second_r;
  logic [CW-1:0]       ic_r, ic_nxt;
  logic [CW-1:0]       oc_r, oc_nxt;
  logic                mv_pend_r, mv_pend_nxt;
  logic                err_r, err_nxt;
  logic [STATUS_W-1:0] err_status_r, err_status_nxt;
  logic                func_r;
  logic [DATA_W-1:0]   value_r;

  logic [CAPW-1:0] cap_a, cap_b, in_cap;
  logic            in_full;
  logic            accept;

  logic              in_we, in_re, out_we, out_re;
  logic [AW-1:0]     in_waddr, in_raddr, out_waddr, out_raddr;
  logic [DATA_W-1:0] in_wdata, in_rdata, out_rdata;
  logic [CW-1:0]     ic_dec, oc_dec;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign ic_dec = ic_r - CW'(1);
  assign oc_dec = oc_r - CW'(1);

  always_comb begin
    cap_a = CAPW'(cap_first_r);
    cap_b = CAPW'(cap_second_r);
    if (cap_a == '0) begin
      cap_a = ONE_C;
    end else if (cap_a > DEPTH_C) begin
      cap_a = DEPTH_C;
    end
    if (cap_b == '0) begin
      cap_b = ONE_C;
    end else if (cap_b > DEPTH_C) begin
      cap_b = DEPTH_C;
    end
    in_cap  = (cap_a < cap_b) ? cap_a : cap_b;
    in_full = (CAPW'(ic_r) >= in_cap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_first_r  <= CAP_RESET;
      cap_second_r <= CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_CAP:  cap_first_r  <= cfg_wdata;
        CFG_SECOND_CAP: cap_second_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.func == FUNC_ADD) begin
            if (in_full && oc_r == '0) begin
              state_nxt = ST_XFER;
            end
          end else if (oc_r != '0) begin
            state_nxt = ST_POP;
          end else if (ic_r != '0) begin
            state_nxt = ST_XFER;
          end
        end
      end
      ST_XFER: begin
        if (ic_r == '0) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = (func_r == FUNC_ADD) ? ST_IDLE : ST_POP;
      end
      ST_POP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ic_nxt         = ic_r;
    oc_nxt         = oc_r;
    mv_pend_nxt    = 1'b0;
    err_nxt        = 1'b0;
    err_status_nxt = err_status_r;
    in_we          = 1'b0;
    in_waddr       = ic_r[AW-1:0];
    in_wdata       = in_word.add_value;
    in_re          = 1'b0;
    in_raddr       = ic_dec[AW-1:0];
    out_we         = 1'b0;
    out_waddr      = oc_r[AW-1:0];
    out_re         = 1'b0;
    out_raddr      = oc_dec[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.func == FUNC_ADD) begin
            if (!in_full) begin
              in_we  = 1'b1;
              ic_nxt = ic_r + CW'(1);
            end else if (oc_r != '0) begin
              err_nxt        = 1'b1;
              err_status_nxt = STATUS_FULL;
            end
          end else if (oc_r != '0) begin
            out_re = 1'b1;
            oc_nxt = oc_dec;
          end else if (ic_r == '0) begin
            err_nxt        = 1'b1;
            err_status_nxt = STATUS_EMPTY;
          end
        end
      end
      ST_XFER: begin
        if (ic_r != '0) begin
          in_re       = 1'b1;
          ic_nxt      = ic_dec;
          mv_pend_nxt = 1'b1;
        end
        if (mv_pend_r) begin
          out_we = 1'b1;
          oc_nxt = oc_r + CW'(1);
        end
      end
      ST_FINISH: begin
        if (func_r == FUNC_ADD) begin
          in_we    = 1'b1;
          in_wdata = value_r;
          ic_nxt   = ic_r + CW'(1);
        end else begin
          out_re = 1'b1;
          oc_nxt = oc_dec;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ic_r         <= '0;
      oc_r         <= '0;
      mv_pend_r    <= 1'b0;
      err_r        <= 1'b0;
      err_status_r <= STATUS_OK;
    end else begin
      state_r      <= state_nxt;
      ic_r         <= ic_nxt;
      oc_r         <= oc_nxt;
      mv_pend_r    <= mv_pend_nxt;
      err_r        <= err_nxt;
      err_status_r <= err_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_word.func;
      value_r <= in_word.add_value;
    end
  end

  tsbq_stack_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_in_stack (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (in_wdata),
    .re    (in_re),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  tsbq_stack_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_out_stack (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (in_rdata),
    .re    (out_re),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

  always_comb begin
    out_strobe = err_r || (state_r == ST_POP);
    if (state_r == ST_POP) begin
      out_word.status    = STATUS_OK;
      out_word.out_value = out_rdata;
    end else begin
      out_word.status    = err_r ? err_status_r : STATUS_OK;
      out_word.out_value = '0;
    end
  end

  a_one_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(err_r && state_r == ST_POP))
    else $error("error word and popped word in the same cycle");

  a_xfer_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && state_nxt == ST_XFER) |-> (oc_r == '0 && ic_r != '0))
    else $error("transfer started with output stack not empty or input stack empty");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (CAPW'(ic_r) <= DEPTH_C) && (CAPW'(oc_r) <= DEPTH_C))
    else $error("stack count beyond depth");

  a_finish_input_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (ic_r == '0 && !mv_pend_r))
    else $error("transfer finished with entries left over");

  a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_POP) ##1 (state_r == ST_POP) |-> $past(out_re))
    else $error("pop word without a read of the output stack");

endmodule

FILE: hw/rtl/tsbq_stack_mem.sv
// Single stack store: one write port and one read port with registered read data.
// Depends on tsbq_pkg for the data width.
module tsbq_stack_mem
  import tsbq_pkg::*;
#(
  parameter int DEPTH = TSBQ_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: bench/two_stack_bounded_queue_core_test.sv
// Self-checking testbench for two_stack_bounded_queue_core: a directed table, then random phases.
// Every accepted word is predicted locally; depends on tsbq_pkg and the core alone.
`timescale 1ns / 100ps

module two_stack_bounded_queue_core_test;
  import tsbq_pkg::*;

  localparam int DEPTH       = TSBQ_DEPTH;
  localparam int ITEM_TARGET = 1350;
  localparam int CALM_TAIL   = 200;

  typedef enum logic {ROW_OP, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    in_word_t             word;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_val;
    bit                   typed;
    out_word_t            want;
  } script_row_t;

  localparam out_word_t NO_WORD = '0;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_word_t             in_word = '0;
  logic                 out_strobe;
  out_word_t            out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic [DATA_W-1:0] in_stk [DEPTH];
  logic [DATA_W-1:0] out_stk [DEPTH];
  int unsigned       in_fill;
  int unsigned       out_fill;
  logic [CFG_W-1:0]  first_cap;
  logic [CFG_W-1:0]  second_cap;

  out_word_t pending_words [$];
  int        mismatches;
  int        items_sent;
  int        words_checked;
  int        full_seen;
  int        empty_seen;
  int        settings_used;

  script_row_t script [0:28];

  two_stack_bounded_queue_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned eff_cap(input logic [CFG_W-1:0] c);
    if (c == 0) return 1;
    if (c > DEPTH) return DEPTH;
    return 32'(c);
  endfunction

  function automatic void shift_to_output();
    while (in_fill > 0 && out_fill < DEPTH) begin
      in_fill--;
      out_stk[out_fill] = in_stk[in_fill];
      out_fill++;
    end
  endfunction

  function automatic void predict_queue_op(input in_word_t w, output bit gives,
                                           output out_word_t res);
    int unsigned cap_a;
    int unsigned cap_b;
    int unsigned in_cap;
    gives  = 1'b0;
    res    = '0;
    cap_a  = eff_cap(first_cap);
    cap_b  = eff_cap(second_cap);
    in_cap = (cap_a < cap_b) ? cap_a : cap_b;
    if (w.func == FUNC_ADD) begin
      if (in_fill >= in_cap) begin
        if (out_fill != 0) begin
          gives = 1'b1;
          res.status = STATUS_FULL;
          return;
        end
        shift_to_output();
      end
      if (in_fill < DEPTH) begin
        in_stk[in_fill] = w.add_value;
        in_fill++;
      end
      return;
    end
    if (out_fill == 0) begin
      if (in_fill == 0) begin
        gives = 1'b1;
        res.status = STATUS_EMPTY;
        return;
      end
      shift_to_output();
    end
    out_fill--;
    gives = 1'b1;
    res.status = STATUS_OK;
    res.out_value = out_stk[out_fill];
  endfunction

  task automatic issue_word(input in_word_t w, input bit typed, input out_word_t want);
    bit        gives;
    out_word_t res;
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_queue_op(w, gives, res);
    if (typed) pending_words.push_back(want);
    else if (gives) pending_words.push_back(res);
    items_sent++;
  endtask

  task automatic settle_idle();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIRST_CAP) first_cap = val;
    else second_cap = val;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_cap();
    case ($urandom_range(0, 11))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;
      4, 5:    return CFG_W'($urandom_range(2, 6));
      default: return CFG_W'($urandom_range(1, 64));
    endcase
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_strobe) begin
      if (out_word.status == STATUS_FULL) full_seen++;
      if (out_word.status == STATUS_EMPTY) empty_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected word: status %0d, out_value %0d", out_word.status,
               out_word.out_value);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          mismatches++;
        end
        if (out_word.out_value !== want.out_value) begin
          $error("out_value: expected %0d, got %0d", want.out_value, out_word.out_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int          row;
    int          phase;
    int          phase_len;
    int          add_pct;
    int          gap_pct;
    int          gap;
    int          wait_cycles;
    in_word_t    w;

    in_fill    = 0;
    out_fill   = 0;
    first_cap  = CAP_RESET;
    second_cap = CAP_RESET;
    for (int k = 0; k < DEPTH; k++) begin
      in_stk[k]  = '0;
      out_stk[k] = '0;
    end

    // Extremes after reset, the one-entry input stack, a full error after a capacity
    // drop below the fill level, and the empty error once both stacks run dry.
    script = '{
      '{ROW_OP,  '{FUNC_DEL, 32'sd0}, CFG_FIRST_CAP, 7'd0, 1'b1, '{STATUS_EMPTY, 32'sd0}},
      '{ROW_OP,  '{FUNC_ADD, 32'sh7FFF_FFFF}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_ADD, 32'sh8000_0000}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_ADD, 32'sd0}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_ADD, 32'shFFFF_FFFF}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_DEL, 32'shFFFF_FFFF}, CFG_FIRST_CAP, 7'd0, 1'b1,
        '{STATUS_OK, 32'sh7FFF_FFFF}},
      '{ROW_OP,  '{FUNC_DEL, 32'sd0}, CFG_FIRST_CAP, 7'd0, 1'b1,
        '{STATUS_OK, 32'sh8000_0000}},
      '{ROW_OP,  '{FUNC_DEL, 32'sh5A5A_A5A5}, CFG_FIRST_CAP, 7'd0, 1'b1,
        '{STATUS_OK, 32'sd0}},
      '{ROW_OP,  '{FUNC_DEL, 32'sd0}, CFG_FIRST_CAP, 7'd0, 1'b1,
        '{STATUS_OK, 32'shFFFF_FFFF}},
      '{ROW_OP,  '{FUNC_DEL, 32'sd0}, CFG_FIRST_CAP, 7'd0, 1'b1, '{STATUS_EMPTY, 32'sd0}},
      '{ROW_CFG, '0, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_ADD, 32'sd1}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_ADD, 32'sd2}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_ADD, 32'sd3}, CFG_FIRST_CAP, 7'd0, 1'b1, '{STATUS_FULL, 32'sd0}},
      '{ROW_OP,  '{FUNC_DEL, 32'sd0}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_DEL, 32'sd0}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_DEL, 32'sd0}, CFG_FIRST_CAP, 7'd0, 1'b1, '{STATUS_EMPTY, 32'sd0}},
      '{ROW_CFG, '0, CFG_FIRST_CAP, 7'd127, 1'b0, NO_WORD},
      '{ROW_CFG, '0, CFG_SECOND_CAP, 7'd2, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_ADD, 32'sd5}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_ADD, 32'sd6}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_ADD, 32'sd7}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_ADD, 32'sd8}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_ADD, 32'sd9}, CFG_FIRST_CAP, 7'd0, 1'b1, '{STATUS_FULL, 32'sd0}},
      '{ROW_CFG, '0, CFG_SECOND_CAP, 7'd1, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_ADD, 32'sd10}, CFG_FIRST_CAP, 7'd0, 1'b1, '{STATUS_FULL, 32'sd0}},
      '{ROW_OP,  '{FUNC_DEL, 32'sd0}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_DEL, 32'sd0}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD},
      '{ROW_OP,  '{FUNC_DEL, 32'sd0}, CFG_FIRST_CAP, 7'd0, 1'b0, NO_WORD}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < 29; row++) begin
      if (script[row].kind == ROW_CFG) begin
        settle_idle();
        write_cap(script[row].cfg_idx, script[row].cfg_val);
      end else begin
        issue_word(script[row].word, script[row].typed, script[row].want);
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle_idle();
      case (phase)
        0: begin write_cap(CFG_FIRST_CAP, 7'd64); write_cap(CFG_SECOND_CAP, 7'd64); end
        1: begin write_cap(CFG_FIRST_CAP, 7'd1); write_cap(CFG_SECOND_CAP, 7'd0); end
        2: begin write_cap(CFG_FIRST_CAP, 7'd127); write_cap(CFG_SECOND_CAP, 7'd3); end
        3: begin write_cap(CFG_FIRST_CAP, 7'd0); write_cap(CFG_SECOND_CAP, 7'd127); end
        default: begin
          write_cap(CFG_FIRST_CAP, pick_cap());
          write_cap(CFG_SECOND_CAP, pick_cap());
        end
      endcase
      settings_used++;
      case ($urandom_range(0, 2))
        0:       add_pct = 15;
        1:       add_pct = 50;
        default: add_pct = 85;
      endcase
      gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 30;
      phase_len = $urandom_range(60, 130);
      repeat (phase_len) begin
        w.func = ($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_DEL;
        case ($urandom_range(0, 15))
          0:       w.add_value = 32'sh7FFF_FFFF;
          1:       w.add_value = 32'sh8000_0000;
          2:       w.add_value = 32'sd0;
          3:       w.add_value = 32'shFFFF_FFFF;
          default: w.add_value = $urandom;
        endcase
        gap = 0;
        if (items_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(0, 99) < gap_pct)
          gap = $urandom_range(1, 3);
        if (items_sent < ITEM_TARGET - CALM_TAIL && $urandom_range(0, 99) == 0) begin
          start <= 1'b0;
          while (pending_words.size() != 0) @(posedge clk);
        end else if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        issue_word(w, 1'b0, NO_WORD);
      end
      phase++;
    end

    start <= 1'b0;
    wait_cycles = 0;
    while (pending_words.size() != 0 && wait_cycles < 8 * DEPTH) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DEPTH + 8) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      mismatches += pending_words.size();
    end

    $display("Ran %0d queue operations over %0d capacity settings; %0d words checked.",
             items_sent, settings_used, words_checked);
    $display("Seen %0d full errors and %0d empty errors.", full_seen, empty_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
